/* sv/sorted_timetable_row_search_top_macros.svh */
// ----------------------------------------------------------------------------
// sorted timetable row search assertion macros
// concurrent assertion helpers used by the block's top-level rtl file
// ----------------------------------------------------------------------------
`ifndef SORTED_TIMETABLE_ROW_SEARCH_TOP_MACROS_SVH
`define SORTED_TIMETABLE_ROW_SEARCH_TOP_MACROS_SVH

`ifndef SYNTH

// check with reset masking
`define STTRS_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// check that also holds around reset
`define STTRS_ASSERT_ALWAYS(name, clk, prop, msg) \
   name: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define STTRS_ASSERT(name, clk, rst, prop, msg)
`define STTRS_ASSERT_ALWAYS(name, clk, prop, msg)

`endif

`endif

/* sv/sttrs_pkg.sv */
// ----------------------------------------------------------------------------
// sorted timetable row search package
// sizes, codes and helpers shared by the table search block
// ----------------------------------------------------------------------------
`default_nettype none

package sttrs_pkg;

   localparam int STOPS      = 8;
   localparam int MAX_ROWS   = 64;
   localparam int TIME_WIDTH = 16;

   localparam int TIME_BITS = 16;
   localparam int PLEN_W    = 6;
   localparam int STOP_W    = (STOPS > 1) ? $clog2(STOPS) : 1;
   localparam int ROW_W     = $clog2(MAX_ROWS);
   localparam int CNT_W     = $clog2(MAX_ROWS + 1);
   localparam int ADDR_W    = $clog2(MAX_ROWS * STOPS);
   localparam int LEFT_W    = $clog2(MAX_ROWS * STOPS + 1);

   localparam logic [TIME_BITS-1:0] TIME_MASK =
      TIME_BITS'((64'd1 << TIME_WIDTH) - 64'd1);
   localparam logic [PLEN_W-1:0] PLEN_MAX = '1;

   typedef enum logic [1:0] {
      ACT_INSERT  = 2'd0,
      ACT_READ    = 2'd1,
      ACT_NOTLESS = 2'd2,
      ACT_NOTGRTR = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      STS_OK       = 3'd0,
      STS_NOTFOUND = 3'd1,
      STS_BADLEN   = 3'd2,
      STS_FULL     = 3'd3,
      STS_BADIDX   = 3'd4
   } status_type;

   typedef struct packed {
      logic                 en;
      logic [ADDR_W-1:0]    addr;
      logic [TIME_BITS-1:0] data;
   } mem_wr_type;

   function automatic logic [ADDR_W-1:0] row_addr(input logic [ROW_W-1:0] row,
                                                  input logic [STOP_W-1:0] stop);
      return ADDR_W'(row) * ADDR_W'(STOPS) + ADDR_W'(stop);
   endfunction

endpackage

`default_nettype wire

/* sv/sttrs_row_ram.sv */
// ----------------------------------------------------------------------------
// row store memory
// one write port and one registered read port holding all table rows
// ----------------------------------------------------------------------------
`default_nettype none

module sttrs_row_ram import sttrs_pkg::*; (
   input  wire logic                 clock,
   input  wire mem_wr_type           wr,
   input  wire logic [ADDR_W-1:0]    rd_addr,
   output logic      [TIME_BITS-1:0] rd_data
);

   logic [TIME_BITS-1:0] mem [MAX_ROWS*STOPS];
   logic [TIME_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* sv/sorted_timetable_row_search_top.sv */
// ----------------------------------------------------------------------------
// sorted timetable row search
// sorted table of timetable rows with insert, column read and searches
// ----------------------------------------------------------------------------
// usage:
//   req_ carries one transaction at a time; req_stall stays high while a
//   transaction is worked on. rsp_ returns its results, rsp_last on the final.
//   insert elements without row_end give no result.
//   a row end runs a lexicographic halving search over the table, one
//   compared stop at a time and up to log2(rows)+1 probes, then moves every
//   later row down one word per cycle and writes the new row stop by stop.
//   a column read returns one result per row, in row order.
//   a search reads and compares one probe at a time, then reads the found row.
//   a result sits in an output register, so the next transaction is taken
//   while rsp_stall holds a result; a held result then delays the next one.
//   reset empties the table and the partial row; the row memory keeps its
//   contents, which are never read before being rewritten.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sorted_timetable_row_search_top_macros.svh"

module sorted_timetable_row_search_top import sttrs_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_action,
   input  wire logic [4:0]  req_stop_index,
   input  wire logic [15:0] req_time_req,
   input  wire logic        req_row_end,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [2:0]       rsp_status,
   output logic [5:0]       rsp_row_index,
   output logic [15:0]      rsp_time_out,
   output logic             rsp_last
);

   typedef enum logic [11:0] {
      ST_IDLE      = 12'b0000_0000_0001,
      ST_LEX_RD    = 12'b0000_0000_0010,
      ST_LEX_CK    = 12'b0000_0000_0100,
      ST_SHIFT_SET = 12'b0000_0000_1000,
      ST_COPY      = 12'b0000_0001_0000,
      ST_FILL      = 12'b0000_0010_0000,
      ST_COL_RD    = 12'b0000_0100_0000,
      ST_COL_CK    = 12'b0000_1000_0000,
      ST_SRCH_RD   = 12'b0001_0000_0000,
      ST_SRCH_CK   = 12'b0010_0000_0000,
      ST_SRCH_FIN  = 12'b0100_0000_0000,
      ST_EMIT      = 12'b1000_0000_0000
   } state_type;

   state_type state_ff, state_in;

   logic [CNT_W-1:0]     row_count_ff, row_count_in;
   logic [PLEN_W-1:0]    pend_len_ff, pend_len_in;
   logic [TIME_BITS-1:0] pend_row_ff [STOPS];
   logic                 pend_we;
   logic [STOP_W-1:0]    pend_idx;
   logic [TIME_BITS-1:0] pend_data;

   logic [CNT_W-1:0]     first_ff, first_in;
   logic [CNT_W-1:0]     len_ff, len_in;
   logic [STOP_W-1:0]    s_ff, s_in;
   logic [STOP_W-1:0]    stop_ff, stop_in;
   logic [TIME_BITS-1:0] key_ff, key_in;
   logic                 rev_ff, rev_in;
   logic [CNT_W-1:0]     col_row_ff, col_row_in;

   logic [ADDR_W-1:0]    cp_addr_ff, cp_addr_in;
   logic [LEFT_W-1:0]    cp_left_ff, cp_left_in;
   logic                 wr_pend_ff, wr_pend_in;
   logic [ADDR_W-1:0]    wr_addr_ff, wr_addr_in;

   status_type           res_status_ff, res_status_in;
   logic [ROW_W-1:0]     res_row_ff, res_row_in;
   logic [TIME_BITS-1:0] res_time_ff, res_time_in;
   logic                 res_last_ff, res_last_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   status_type           rsp_status_ff;
   logic [ROW_W-1:0]     rsp_row_ff;
   logic [TIME_BITS-1:0] rsp_time_ff;
   logic                 rsp_last_ff;
   logic                 rsp_load;
   logic                 out_free;

   mem_wr_type           mem_wr;
   logic [ADDR_W-1:0]    mem_rd_addr;
   logic [TIME_BITS-1:0] mem_rd_data;

   logic                 req_take;
   logic [TIME_BITS-1:0] req_time;
   logic [PLEN_W-1:0]    pend_len_inc;
   logic [CNT_W-1:0]     half;
   logic [CNT_W-1:0]     mid;
   logic [CNT_W-1:0]     srch_row;
   logic [CNT_W-1:0]     fin_row;
   logic                 go_right;
   logic                 lex_differ;

   sttrs_row_ram u_row_ram (
      .clock   (clock),
      .wr      (mem_wr),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   assign req_stall    = (state_ff != ST_IDLE);
   assign req_take     = req_valid && !req_stall;
   assign req_time     = req_time_req & TIME_MASK;
   assign pend_len_inc = (pend_len_ff == PLEN_MAX) ? pend_len_ff : pend_len_ff + PLEN_W'(1);
   assign out_free     = !rsp_valid_ff || !rsp_stall;

   assign half     = len_ff >> 1;
   assign mid      = first_ff + half;
   assign srch_row = rev_ff ? CNT_W'(row_count_ff - CNT_W'(1) - mid) : mid;
   assign fin_row  = rev_ff ? CNT_W'(row_count_ff - CNT_W'(1) - first_ff) : first_ff;
   assign lex_differ = (mem_rd_data != pend_row_ff[s_ff]);

   always_comb begin
      state_in      = state_ff;
      row_count_in  = row_count_ff;
      pend_len_in   = pend_len_ff;
      pend_we       = 1'b0;
      pend_idx      = pend_len_ff[STOP_W-1:0];
      pend_data     = req_time;
      first_in      = first_ff;
      len_in        = len_ff;
      s_in          = s_ff;
      stop_in       = stop_ff;
      key_in        = key_ff;
      rev_in        = rev_ff;
      col_row_in    = col_row_ff;
      cp_addr_in    = cp_addr_ff;
      cp_left_in    = cp_left_ff;
      wr_pend_in    = 1'b0;
      wr_addr_in    = wr_addr_ff;
      res_status_in = res_status_ff;
      res_row_in    = res_row_ff;
      res_time_in   = res_time_ff;
      res_last_in   = res_last_ff;
      rsp_load      = 1'b0;
      mem_rd_addr   = cp_addr_ff;
      go_right      = 1'b0;
      mem_wr.en     = wr_pend_ff;
      mem_wr.addr   = wr_addr_ff;
      mem_wr.data   = mem_rd_data;

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               res_status_in = STS_OK;
               res_row_in    = '0;
               res_time_in   = '0;
               res_last_in   = 1'b1;
               first_in      = '0;
               len_in        = row_count_ff;
               s_in          = '0;
               key_in        = req_time;
               rev_in        = (req_action == ACT_NOTGRTR);
               stop_in       = req_stop_index[STOP_W-1:0];
               col_row_in    = '0;
               if (req_action == ACT_INSERT) begin
                  pend_we     = (pend_len_ff < PLEN_W'(STOPS));
                  pend_len_in = pend_len_inc;
                  if (req_row_end) begin
                     pend_len_in = '0;
                     if (pend_len_inc != PLEN_W'(STOPS)) begin
                        res_status_in = STS_BADLEN;
                        state_in      = ST_EMIT;
                     end else if (row_count_ff >= CNT_W'(MAX_ROWS)) begin
                        res_status_in = STS_FULL;
                        state_in      = ST_EMIT;
                     end else begin
                        state_in = ST_LEX_RD;
                     end
                  end
               end else if ({1'b0, req_stop_index} >= 6'(STOPS)) begin
                  res_status_in = STS_BADIDX;
                  state_in      = ST_EMIT;
               end else if (req_action == ACT_READ) begin
                  if (row_count_ff == '0) begin
                     res_status_in = STS_NOTFOUND;
                     state_in      = ST_EMIT;
                  end else begin
                     state_in = ST_COL_RD;
                  end
               end else begin
                  state_in = ST_SRCH_RD;
               end
            end
         end
         ST_LEX_RD: begin
            mem_rd_addr = row_addr(ROW_W'(mid), s_ff);
            state_in    = (len_ff == '0) ? ST_SHIFT_SET : ST_LEX_CK;
         end
         ST_LEX_CK: begin
            if (lex_differ || s_ff == STOP_W'(STOPS - 1)) begin
               go_right = lex_differ && (mem_rd_data < pend_row_ff[s_ff]);
               if (go_right) begin
                  first_in = mid + CNT_W'(1);
                  len_in   = len_ff - half - CNT_W'(1);
               end else begin
                  len_in = half;
               end
               s_in     = '0;
               state_in = ST_LEX_RD;
            end else begin
               s_in     = s_ff + STOP_W'(1);
               state_in = ST_LEX_RD;
            end
         end
         ST_SHIFT_SET: begin
            cp_addr_in = ADDR_W'(LEFT_W'(row_count_ff) * LEFT_W'(STOPS) - LEFT_W'(1));
            cp_left_in = LEFT_W'(row_count_ff - first_ff) * LEFT_W'(STOPS);
            s_in       = '0;
            state_in   = ST_COPY;
         end
         ST_COPY: begin
            mem_rd_addr = cp_addr_ff;
            if (cp_left_ff != '0) begin
               cp_addr_in = cp_addr_ff - ADDR_W'(1);
               cp_left_in = cp_left_ff - LEFT_W'(1);
               wr_pend_in = 1'b1;
               wr_addr_in = cp_addr_ff + ADDR_W'(STOPS);
            end else begin
               state_in = ST_FILL;
            end
         end
         ST_FILL: begin
            mem_wr.en   = 1'b1;
            mem_wr.addr = row_addr(ROW_W'(first_ff), s_ff);
            mem_wr.data = pend_row_ff[s_ff];
            if (s_ff == STOP_W'(STOPS - 1)) begin
               row_count_in  = row_count_ff + CNT_W'(1);
               res_status_in = STS_OK;
               res_row_in    = ROW_W'(first_ff);
               state_in      = ST_EMIT;
            end else begin
               s_in = s_ff + STOP_W'(1);
            end
         end
         ST_COL_RD: begin
            mem_rd_addr = row_addr(ROW_W'(col_row_ff), stop_ff);
            state_in    = ST_COL_CK;
         end
         ST_COL_CK: begin
            res_status_in = STS_OK;
            res_row_in    = ROW_W'(col_row_ff);
            res_time_in   = mem_rd_data;
            res_last_in   = (CNT_W'(col_row_ff + CNT_W'(1)) == row_count_ff);
            col_row_in    = col_row_ff + CNT_W'(1);
            state_in      = ST_EMIT;
         end
         ST_SRCH_RD: begin
            if (len_ff != '0) begin
               mem_rd_addr = row_addr(ROW_W'(srch_row), stop_ff);
               state_in    = ST_SRCH_CK;
            end else begin
               mem_rd_addr = row_addr(ROW_W'(fin_row), stop_ff);
               if (first_ff >= row_count_ff) begin
                  res_status_in = STS_NOTFOUND;
                  state_in      = ST_EMIT;
               end else begin
                  state_in = ST_SRCH_FIN;
               end
            end
         end
         ST_SRCH_CK: begin
            go_right = rev_ff ? (mem_rd_data > key_ff) : (mem_rd_data < key_ff);
            if (go_right) begin
               first_in = mid + CNT_W'(1);
               len_in   = len_ff - half - CNT_W'(1);
            end else begin
               len_in = half;
            end
            state_in = ST_SRCH_RD;
         end
         ST_SRCH_FIN: begin
            res_status_in = STS_OK;
            res_row_in    = ROW_W'(fin_row);
            res_time_in   = mem_rd_data;
            state_in      = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_load = 1'b1;
               state_in = res_last_ff ? ST_IDLE : ST_COL_RD;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         row_count_ff <= '0;
         pend_len_ff  <= '0;
         wr_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         row_count_ff <= row_count_in;
         pend_len_ff  <= pend_len_in;
         wr_pend_ff   <= wr_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      first_ff      <= first_in;
      len_ff        <= len_in;
      s_ff          <= s_in;
      stop_ff       <= stop_in;
      key_ff        <= key_in;
      rev_ff        <= rev_in;
      col_row_ff    <= col_row_in;
      cp_addr_ff    <= cp_addr_in;
      cp_left_ff    <= cp_left_in;
      wr_addr_ff    <= wr_addr_in;
      res_status_ff <= res_status_in;
      res_row_ff    <= res_row_in;
      res_time_ff   <= res_time_in;
      res_last_ff   <= res_last_in;
      if (pend_we) begin
         pend_row_ff[pend_idx] <= pend_data;
      end
      if (rsp_load) begin
         rsp_status_ff <= res_status_ff;
         rsp_row_ff    <= res_row_ff;
         rsp_time_ff   <= res_time_ff;
         rsp_last_ff   <= res_last_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_row_index = 6'(rsp_row_ff);
   assign rsp_time_out  = rsp_time_ff;
   assign rsp_last      = rsp_last_ff;

   `STTRS_ASSERT(a_count_bound, clock, reset,
      row_count_ff <= CNT_W'(MAX_ROWS), "row count beyond capacity")
   `STTRS_ASSERT(a_copy_in_shift, clock, reset,
      wr_pend_ff |-> (state_ff == ST_COPY), "row move write outside shift")
   `STTRS_ASSERT(a_count_step, clock, reset,
      (row_count_ff != $past(row_count_ff)) |-> ($past(state_ff) == ST_FILL),
      "row count changed outside fill")
   `STTRS_ASSERT(a_partial_row_silent, clock, reset,
      (req_take && req_action == ACT_INSERT && !req_row_end) |=> (state_ff == ST_IDLE),
      "partial row element left idle")
   `STTRS_ASSERT_ALWAYS(a_reset_idle, clock,
      reset |=> (state_ff == ST_IDLE && !rsp_valid_ff), "not idle after reset")

endmodule

`default_nettype wire

/* tb/sv/tb_sorted_timetable_row_search_top.sv */
// ----------------------------------------------------------------------------
// sorted timetable row search testbench
// drives rows, column reads and both searches with random idling on both
// channels, predicts every result from a private copy of the table and
// checks each result field by field in order
// ----------------------------------------------------------------------------

module tb_sorted_timetable_row_search_top;
   import sttrs_pkg::*;

   localparam int RANDOM_ITEMS = 220;
   localparam int TAIL_ITEMS   = 23;
   localparam int HOLD_CYCLES  = 500;
   localparam int DRAIN_CYCLES = 200;
   localparam int LIMIT_CYCLES = 2_000_000;

   localparam int FILL_ZERO = 0;
   localparam int FILL_ONES = 1;
   localparam int FILL_FEW  = 2;
   localparam int FILL_ANY  = 3;
   localparam int FILL_COPY = 4;

   class timetable_scoreboard;
      typedef struct {
         status_type  status;
         logic [5:0]  row;
         logic [15:0] t;
         logic        last;
      } row_result_type;

      logic [15:0]    rows [MAX_ROWS*STOPS];
      int             n_rows;
      logic [15:0]    part_row [32];
      int             part_len;
      row_result_type awaited [$];
      int             n_errors;
      int             n_checked;

      function new();
         n_rows    = 0;
         part_len  = 0;
         n_errors  = 0;
         n_checked = 0;
      endfunction

      function void queue_result(status_type st, int r, logic [15:0] v, logic l);
         row_result_type e;
         e.status = st;
         e.row    = 6'(r);
         e.t      = v;
         e.last   = l;
         awaited.insert(awaited.size(), e);
      endfunction

      // stored row r sorts strictly ahead of the pending row
      function bit row_precedes(int r);
         for (int s = 0; s < STOPS; s++) begin
            if (rows[r*STOPS+s] != part_row[s]) return rows[r*STOPS+s] < part_row[s];
         end
         return 1'b0;
      endfunction

      function int insert_slot();
         int first;
         int len;
         int half;
         first = 0;
         len   = n_rows;
         while (len > 0) begin
            half = len / 2;
            if (row_precedes(first + half)) begin
               first = first + half + 1;
               len   = len - half - 1;
            end else begin
               len = half;
            end
         end
         return first;
      endfunction

      // halving over one column, the reverse pass walks the rows from the end
      function int halving_probe(int stop, logic [15:0] key, bit rev);
         int first;
         int len;
         int half;
         int mid;
         bit right;
         first = 0;
         len   = n_rows;
         while (len > 0) begin
            half = len / 2;
            mid  = first + half;
            if (rev) right = rows[(n_rows-1-mid)*STOPS+stop] > key;
            else right = rows[mid*STOPS+stop] < key;
            if (right) begin
               first = mid + 1;
               len   = len - half - 1;
            end else begin
               len = half;
            end
         end
         return first;
      endfunction

      function void note_request(action_type act, logic [4:0] stop, logic [15:0] t,
                                 logic rend);
         int pos;
         int k;
         int r;
         if (act == ACT_INSERT) begin
            if (part_len < 32) part_row[part_len] = t & TIME_MASK;
            if (part_len < 63) part_len++;
            if (rend) begin
               if (part_len != STOPS) begin
                  part_len = 0;
                  queue_result(STS_BADLEN, 0, 16'h0, 1'b1);
               end else begin
                  part_len = 0;
                  if (n_rows >= MAX_ROWS) begin
                     queue_result(STS_FULL, 0, 16'h0, 1'b1);
                  end else begin
                     pos = insert_slot();
                     for (int i = n_rows; i > pos; i--)
                        for (int s = 0; s < STOPS; s++) rows[i*STOPS+s] = rows[(i-1)*STOPS+s];
                     for (int s = 0; s < STOPS; s++) rows[pos*STOPS+s] = part_row[s];
                     n_rows++;
                     queue_result(STS_OK, pos, 16'h0, 1'b1);
                  end
               end
            end
         end else if (int'(stop) >= STOPS) begin
            queue_result(STS_BADIDX, 0, 16'h0, 1'b1);
         end else if (act == ACT_READ) begin
            if (n_rows == 0) queue_result(STS_NOTFOUND, 0, 16'h0, 1'b1);
            for (int i = 0; i < n_rows; i++)
               queue_result(STS_OK, i, rows[i*STOPS+int'(stop)], i == n_rows - 1);
         end else begin
            k = halving_probe(int'(stop), t & TIME_MASK, act == ACT_NOTGRTR);
            if (k >= n_rows) begin
               queue_result(STS_NOTFOUND, 0, 16'h0, 1'b1);
            end else begin
               r = (act == ACT_NOTGRTR) ? n_rows - 1 - k : k;
               queue_result(STS_OK, r, rows[r*STOPS+int'(stop)], 1'b1);
            end
         end
      endfunction

      function void check_response(logic [2:0] st, logic [5:0] row, logic [15:0] t,
                                   logic l);
         row_result_type e;
         n_checked++;
         if (awaited.size() == 0) begin
            $error("unexpected result: status %0d row %0d time %0d last %0d", st, row, t, l);
            n_errors++;
            return;
         end
         e = awaited.pop_front();
         if (st !== e.status) begin
            $error("rsp_status: expected %0d, got %0d", e.status, st);
            n_errors++;
         end
         if (row !== e.row) begin
            $error("rsp_row_index: expected %0d, got %0d", e.row, row);
            n_errors++;
         end
         if (t !== e.t) begin
            $error("rsp_time_out: expected %0d, got %0d", e.t, t);
            n_errors++;
         end
         if (l !== e.last) begin
            $error("rsp_last: expected %0d, got %0d", e.last, l);
            n_errors++;
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_action = ACT_INSERT;
   logic [4:0]  req_stop_index = 5'd0;
   logic [15:0] req_time_req = 16'd0;
   logic        req_row_end = 1'b0;
   logic        rsp_valid;
   logic        rx_stall = 1'b0;
   logic        hold_rsp = 1'b0;
   wire         rsp_stall = rx_stall | hold_rsp;
   logic [2:0]  rsp_status;
   logic [5:0]  rsp_row_index;
   logic [15:0] rsp_time_out;
   logic        rsp_last;

   timetable_scoreboard sb;
   int tx_calm = 0;
   int n_sent = 0;
   int cycles = 0;

   sorted_timetable_row_search_top i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_action     (req_action),
      .req_stop_index (req_stop_index),
      .req_time_req   (req_time_req),
      .req_row_end    (req_row_end),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_row_index  (rsp_row_index),
      .rsp_time_out   (rsp_time_out),
      .rsp_last       (rsp_last)
   );

   always begin
      #2;
      clock = 1'b1;
      #2;
      clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= LIMIT_CYCLES) begin
         $display("FAILURE");
         $finish;
      end
   end

   // idle cycles before the next transaction, with runs of back-to-back traffic
   function automatic int idle_cycles(inout int calm);
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 19) == 0) calm = $urandom_range(10, 40);
      return $urandom_range(0, 18);
   endfunction

   function automatic logic [15:0] pick_elem(int fill);
      case (fill)
         FILL_ZERO: return 16'h0000;
         FILL_ONES: return 16'hffff;
         FILL_FEW:  return 16'($urandom_range(0, 3)) * 16'h5555;
         default:   return 16'($urandom);
      endcase
   endfunction

   function automatic int row_fill();
      case ($urandom_range(0, 5))
         0, 1, 2: return FILL_FEW;
         3:       return FILL_COPY;
         default: return FILL_ANY;
      endcase
   endfunction

   task automatic send(input action_type act, input logic [4:0] stop, input logic [15:0] t,
                       input logic rend);
      int gap;
      gap = idle_cycles(tx_calm);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_action     <= act;
      req_stop_index <= stop;
      req_time_req   <= t;
      req_row_end    <= rend;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      sb.note_request(act, stop, t, rend);
      n_sent++;
   endtask

   // column read or search, keys mostly at or next to stored times
   task automatic send_lookup();
      action_type  act;
      int          stop;
      int          r;
      logic [15:0] key;
      act  = action_type'($urandom_range(1, 3));
      stop = ($urandom_range(0, 9) == 0) ? $urandom_range(STOPS, 31) : $urandom_range(0, STOPS-1);
      key  = 16'($urandom);
      if (sb.n_rows > 0 && stop < STOPS && $urandom_range(0, 3) != 0) begin
         r   = $urandom_range(0, sb.n_rows - 1);
         key = sb.rows[r*STOPS+stop] + 16'($urandom_range(0, 2)) - 16'd1;
      end
      send(act, 5'(stop), key, 1'($urandom));
   endtask

   task automatic send_row(input int len, input int fill);
      int src;
      src = (sb.n_rows > 0) ? $urandom_range(0, sb.n_rows - 1) : 0;
      for (int i = 0; i < len; i++) begin
         logic [15:0] v;
         if (fill == FILL_COPY && sb.n_rows > 0 && i < STOPS) v = sb.rows[src*STOPS+i];
         else v = pick_elem(fill);
         send(ACT_INSERT, 5'($urandom_range(0, 31)), v, i == len - 1);
         if (i != len - 1 && fill >= FILL_FEW && $urandom_range(0, 11) == 0) send_lookup();
      end
   endtask

   task automatic send_broken_row();
      int len;
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(33, 70) : $urandom_range(1, 12);
      if (len == STOPS) len++;
      send_row(len, row_fill());
   endtask

   // long output hold while the sender keeps offering, so the block backs up
   initial begin
      @(posedge clock);
      while (reset || sb.n_checked < 30) @(posedge clock);
      hold_rsp <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_rsp <= 1'b0;
   end

   initial begin
      int gap;
      int calm;
      calm = 0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         gap = idle_cycles(calm);
         if (gap > 0) begin
            rx_stall <= 1'b1;
            repeat (gap) @(posedge clock);
         end
         rx_stall <= 1'b0;
         @(posedge clock);
         while (!(rsp_valid === 1'b1 && rsp_stall === 1'b0)) @(posedge clock);
         sb.check_response(rsp_status, rsp_row_index, rsp_time_out, rsp_last);
      end
   end

   initial begin
      int stop_at;
      int pick;
      sb = new();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty table, bad stop index, extreme rows, short row
      send(ACT_READ, 5'd0, 16'h0000, 1'b0);
      send(ACT_NOTLESS, 5'd3, 16'h0000, 1'b0);
      send(ACT_NOTGRTR, 5'd7, 16'hffff, 1'b1);
      send(ACT_READ, 5'd31, 16'hffff, 1'b1);
      send(ACT_NOTLESS, 5'(STOPS), 16'h1234, 1'b0);
      send_row(STOPS, FILL_ONES);
      send_row(3, FILL_ZERO);
      send_row(STOPS, FILL_ZERO);
      send(ACT_READ, 5'(STOPS-1), 16'h0000, 1'b0);
      send(ACT_NOTLESS, 5'd2, 16'hffff, 1'b0);
      send(ACT_NOTGRTR, 5'd0, 16'h0000, 1'b1);

      stop_at = RANDOM_ITEMS - TAIL_ITEMS;
      while (n_sent < stop_at) begin
         pick = $urandom_range(0, 99);
         if (pick < 35) send_row(STOPS, row_fill());
         else if (pick < 42) send_broken_row();
         else if (pick < 55) send(ACT_READ, 5'($urandom_range(0, STOPS)), 16'($urandom),
                                  1'($urandom));
         else send_lookup();
      end

      // reads of both ends and a run of lookups over the filled table
      send(ACT_READ, 5'd0, 16'h0000, 1'b0);
      send(ACT_READ, 5'(STOPS-1), 16'hffff, 1'b1);
      for (int i = 0; i < 20; i++) send_lookup();
      send(ACT_READ, 5'($urandom_range(0, STOPS-1)), 16'($urandom), 1'b0);
      req_valid <= 1'b0;

      while (sb.awaited.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.n_errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

/* filelist.f */
+incdir+sv
sv/sttrs_pkg.sv
sv/sttrs_row_ram.sv
sv/sorted_timetable_row_search_top.sv
tb/sv/tb_sorted_timetable_row_search_top.sv
